FILE: rtl/tcw_pkg.sv
`default_nettype none
package tcw_pkg;

  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [7:0] CH_NEWLINE  = 8'd10;
  localparam logic [7:0] CH_RETURN   = 8'd13;
  localparam logic [7:0] CH_BLANK    = 8'h20;
  localparam logic [7:0] COLOR_RESET = 8'h07;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_column;
  } request_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row_out;
    logic [6:0]  cursor_column_out;
    logic        scrolled;
  } result_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_SWEEP,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic accept;
    logic sweep;
    logic result;
  } cmd_t;

  typedef struct packed {
    logic wrap;
    logic sweep_last;
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/text_console_writer.sv
`default_nettype none
// Channel   Handshake               Payload
// request   start / busy            request  (kind, char_code, read_row, read_column)
// result    done (one-cycle strobe) result   (cell_value, cursor_row_out,
//                                             cursor_column_out, scrolled)
// config    color_we                color_data (text_color)
//
// Printable characters, carriage return, newline without scroll, reads and unused
// kinds go from idle straight to the result state: done rises as busy drops,
// since the cell read and the result are each registered once.
// A scroll adds a sweep of COLUMNS blank writes for the new bottom row; storage
// rows rotate, so no cells are copied. A clear adds ROWS*COLUMNS blank writes.
// After reset busy stays high while a sweep sets every cell to 0x0720; color
// writes are taken during that pass. The receiver cannot stall.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire tcw_pkg::request_t request,
  input  wire logic              color_we,
  input  wire logic [7:0]        color_data,
  output logic                   done,
  output tcw_pkg::result_t       result
);

  tcw_pkg::cmd_t    cmd;
  tcw_pkg::status_t status;

  tcw_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kind   (request.kind),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .request    (request),
    .color_we   (color_we),
    .color_data (color_data),
    .cmd        (cmd),
    .status     (status),
    .done       (done),
    .result     (result)
  );

endmodule
`default_nettype wire

FILE: rtl/tcw_ctrl.sv
`default_nettype none
module tcw_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [1:0]       kind,
  input  wire tcw_pkg::status_t status,
  output tcw_pkg::cmd_t         cmd,
  output logic                  busy
);

  tcw_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcw_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tcw_pkg::ST_INIT: begin
        if (status.sweep_last) state_next = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (start) begin
          priority if (kind == tcw_pkg::KIND_CLEAR) begin
            state_next = tcw_pkg::ST_SWEEP;
          end else if (kind == tcw_pkg::KIND_CHAR && status.wrap) begin
            state_next = tcw_pkg::ST_SWEEP;
          end else begin
            state_next = tcw_pkg::ST_RESULT;
          end
        end
      end
      tcw_pkg::ST_SWEEP: begin
        if (status.sweep_last) state_next = tcw_pkg::ST_RESULT;
      end
      tcw_pkg::ST_RESULT: begin
        state_next = tcw_pkg::ST_IDLE;
      end
      default: state_next = tcw_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cmd.accept = (state == tcw_pkg::ST_IDLE) && start;
    cmd.sweep  = (state == tcw_pkg::ST_INIT) || (state == tcw_pkg::ST_SWEEP);
    cmd.result = (state == tcw_pkg::ST_RESULT);
    busy       = (state != tcw_pkg::ST_IDLE);
  end

endmodule
`default_nettype wire

FILE: rtl/tcw_datapath.sv
`default_nettype none
module tcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tcw_pkg::request_t request,
  input  wire logic              color_we,
  input  wire logic [7:0]        color_data,
  input  wire tcw_pkg::cmd_t     cmd,
  output tcw_pkg::status_t       status,
  output logic                   done,
  output tcw_pkg::result_t       result
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);

  logic [15:0]   mem [CELLS];
  logic [15:0]   rdata;

  logic [7:0]    text_color;
  logic [7:0]    blank_attr;
  logic [RW-1:0] cursor_row;
  logic [CW-1:0] cursor_column;
  logic [RW-1:0] top;
  logic [AW-1:0] sweep_count;
  logic [AW-1:0] sweep_end;
  logic          read_hit;
  logic          scrolled;

  logic          is_char, is_nl, is_cr, row_last, col_last, row_step, put_cell;
  logic          read_ok;
  logic [AW-1:0] cursor_addr, read_addr, top_addr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;

  // map a screen row onto its storage row; storage rows rotate on scroll
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] row,
                                             input logic [RW-1:0] base);
    logic [RW:0] s;
    s = {1'b0, row} + {1'b0, base};
    if (s >= (RW+1)'(ROWS)) s = s - (RW+1)'(ROWS);
    return s[RW-1:0];
  endfunction

  always_comb begin
    is_char  = (request.kind == tcw_pkg::KIND_CHAR);
    is_nl    = (request.char_code == tcw_pkg::CH_NEWLINE);
    is_cr    = (request.char_code == tcw_pkg::CH_RETURN);
    row_last = (cursor_row == RW'(ROWS - 1));
    col_last = (cursor_column == CW'(COLUMNS - 1));
    row_step = is_nl || (!is_cr && col_last);
    put_cell = is_char && !is_nl && !is_cr;
    status.wrap       = is_char && row_step && row_last;
    status.sweep_last = (sweep_count == sweep_end);

    cursor_addr = AW'(32'(phys_row(cursor_row, top)) * COLUMNS + 32'(cursor_column));
    top_addr    = AW'(32'(top) * COLUMNS);
    read_ok     = (32'(request.read_row) < ROWS) && (32'(request.read_column) < COLUMNS);
    read_addr   = read_ok ?
        AW'(32'(phys_row(RW'(request.read_row), top)) * COLUMNS
            + 32'(request.read_column)) : '0;

    we    = (cmd.accept && put_cell) || cmd.sweep;
    waddr = cmd.sweep ? sweep_count : cursor_addr;
    wdata = cmd.sweep ? {blank_attr, tcw_pkg::CH_BLANK} : {text_color, request.char_code};
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[read_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color    <= tcw_pkg::COLOR_RESET;
      blank_attr    <= tcw_pkg::COLOR_RESET;
      cursor_row    <= '0;
      cursor_column <= '0;
      top           <= '0;
      sweep_count   <= '0;
      sweep_end     <= AW'(CELLS - 1);
      read_hit      <= 1'b0;
      scrolled      <= 1'b0;
    end else begin
      if (color_we) text_color <= color_data;
      if (cmd.sweep) sweep_count <= sweep_count + AW'(1);
      if (cmd.accept) begin
        scrolled <= 1'b0;
        read_hit <= (request.kind == tcw_pkg::KIND_READ) && read_ok;
        unique case (request.kind)
          tcw_pkg::KIND_CHAR: begin
            if (row_step || is_cr) begin
              cursor_column <= '0;
            end else begin
              cursor_column <= cursor_column + CW'(1);
            end
            if (row_step) begin
              if (row_last) begin
                // retire the top storage row and blank it as the new bottom row
                scrolled    <= 1'b1;
                sweep_count <= top_addr;
                sweep_end   <= AW'(32'(top_addr) + COLUMNS - 1);
                blank_attr  <= text_color;
                top         <= (top == RW'(ROWS - 1)) ? '0 : top + RW'(1);
              end else begin
                cursor_row <= cursor_row + RW'(1);
              end
            end
          end
          tcw_pkg::KIND_CLEAR: begin
            cursor_row    <= '0;
            cursor_column <= '0;
            top           <= '0;
            sweep_count   <= '0;
            sweep_end     <= AW'(CELLS - 1);
            blank_attr    <= text_color;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.result;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result) begin
      result.cell_value        <= read_hit ? rdata : 16'h0000;
      result.cursor_row_out    <= 5'(cursor_row);
      result.cursor_column_out <= 7'(cursor_column);
      result.scrolled          <= scrolled;
    end
  end

`ifndef SYNTHESIS
  a_sweep_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep |-> sweep_count <= sweep_end)
    else $error("sweep ran past its end address");

  a_cursor_top_ok: assert property (@(posedge clk) disable iff (rst)
    (32'(cursor_row) < ROWS) && (32'(top) < ROWS))
    else $error("cursor row or top row out of range");

  a_done_after_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.result))
    else $error("result strobe without a result command");

  a_scroll_one_row: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && status.wrap |=> (32'(sweep_end - sweep_count) == COLUMNS - 1) && scrolled)
    else $error("scroll does not blank exactly one row");
`endif

endmodule
`default_nettype wire
